@@ rtl/core/irpl_pkg.sv @@
// Package with the shared constants and types of the indexed register port.
package irpl_pkg;

  // Widths of the item fields
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OFF_W    = 4;
  localparam int unsigned IDX_W    = 5;
  localparam int unsigned PAL_W    = 6;
  localparam int unsigned PPTR_W   = 4;
  localparam int unsigned BANK_DEPTH = 32;
  localparam int unsigned PAL_DEPTH  = 16;

  // Input tdata packing: port in the low bits, write byte above it
  localparam int unsigned IN_TDATA_W = 24;

  // Reset value of the window base
  localparam logic [PORT_W-1:0] IO_BASE_RESET = 16'h03B0;

  // Offsets inside the sixteen-port window
  localparam logic [OFF_W-1:0] OFF_INDEX  = 4'h4;
  localparam logic [OFF_W-1:0] OFF_DATA   = 4'h5;
  localparam logic [OFF_W-1:0] OFF_MODE   = 4'h8;
  localparam logic [OFF_W-1:0] OFF_STATUS = 4'hA;
  localparam logic [OFF_W-1:0] OFF_SETUP  = 4'hF;

  // Index that routes data writes to the palette
  localparam logic [IDX_W-1:0] PAL_INDEX = 5'h14;

  // Status byte shown in the set phase
  localparam logic [DATA_W-1:0] STATUS_BITS = 8'h81;

  // Access kinds carried in tuser
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // One accepted access held in the input register
  typedef struct packed {
    logic              command;
    logic [PORT_W-1:0] port;
    logic [DATA_W-1:0] write_data;
  } access_t;

endpackage

@@ rtl/core/indexed_register_port_with_palette_load_unit.sv @@
// Top level of the indexed register port with palette load.
// Path: an accepted item is held in the input register, then its result in the result register.
// Throughput: one item per cycle while out_tready is high; the decode and state update sit between
// the two registers, and an empty input register can still take an item while a result waits in the output register.
// Reset: synchronous on rst_n low; clears both registers' valid flags, the bank, the palette,
// index, pointer, mode, setup and status phase, and loads the window base with 0x3B0.
module indexed_register_port_with_palette_load_unit
  import irpl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [15:0] port, [23:16] write_data
  input  logic [0:0]            in_tuser,   // [0] command (0 read, 1 write)
  // Result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [DATA_W-1:0]     out_tdata,  // [7:0] read_data
  output logic [0:0]            out_tuser,  // [0] port_hit
  // Configuration port for the window base
  input  logic                  cfg_wr_en,
  input  logic [PORT_W-1:0]     cfg_wr_data
);

  // Pipeline control and payload registers
  logic              in_valid_r;
  access_t           in_item_r;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_data_r;
  logic              out_hit_r;
  logic              advance;

  // Block state
  logic [PORT_W-1:0] io_base_r;
  logic [DATA_W-1:0] bank_r [BANK_DEPTH];
  logic [PAL_W-1:0]  palette_r [PAL_DEPTH];
  logic [IDX_W-1:0]  index_r, index_nxt;
  logic [PPTR_W-1:0] pal_ptr_r, pal_ptr_nxt;
  logic [DATA_W-1:0] mode_r, mode_nxt;
  logic [DATA_W-1:0] setup_r, setup_nxt;
  logic              status_r, status_nxt;

  // Decode results
  logic              hit;
  logic [PORT_W-1:0] rel_port;
  logic [OFF_W-1:0]  offset;
  logic              bank_we;
  logic              pal_we;
  logic [DATA_W-1:0] read_data;

  // The input register moves on whenever the result register is free or being drained.
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  // Window check with one extra bit so the window never wraps past the top port.
  assign hit = ({1'b0, in_item_r.port} >= {1'b0, io_base_r}) &&
               ({1'b0, in_item_r.port} < ({1'b0, io_base_r} + 17'h00010));
  assign rel_port = in_item_r.port - io_base_r;
  assign offset   = rel_port[OFF_W-1:0];

  // Access decode and next state
  always_comb begin
    index_nxt   = index_r;
    pal_ptr_nxt = pal_ptr_r;
    mode_nxt    = mode_r;
    setup_nxt   = setup_r;
    status_nxt  = status_r;
    bank_we     = 1'b0;
    pal_we      = 1'b0;
    read_data   = '0;
    if (hit) begin
      if (in_item_r.command == CMD_WRITE) begin
        case (offset)
          OFF_INDEX: begin
            index_nxt = in_item_r.write_data[IDX_W-1:0];
            if (in_item_r.write_data[IDX_W-1:0] == PAL_INDEX) begin
              pal_ptr_nxt = '0;
            end
          end
          OFF_DATA: begin
            if (index_r == PAL_INDEX) begin
              pal_we      = 1'b1;
              pal_ptr_nxt = pal_ptr_r + 1'b1;
            end else begin
              bank_we = 1'b1;
            end
          end
          OFF_MODE:  mode_nxt  = in_item_r.write_data;
          OFF_SETUP: setup_nxt = in_item_r.write_data;
          default: ;
        endcase
      end else begin
        case (offset)
          OFF_DATA: read_data = bank_r[index_r];
          OFF_STATUS: begin
            status_nxt = !status_r;
            read_data  = status_r ? '0 : STATUS_BITS;
          end
          default: ;
        endcase
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      in_item_r.command    <= in_tuser[0];
      in_item_r.port       <= in_tdata[PORT_W-1:0];
      in_item_r.write_data <= in_tdata[PORT_W +: DATA_W];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance) begin
      out_data_r <= read_data;
      out_hit_r  <= hit;
    end
  end

  // Scalar state, updated once per item as it leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_r   <= '0;
      pal_ptr_r <= '0;
      mode_r    <= '0;
      setup_r   <= '0;
      status_r  <= 1'b0;
    end else if (advance) begin
      index_r   <= index_nxt;
      pal_ptr_r <= pal_ptr_nxt;
      mode_r    <= mode_nxt;
      setup_r   <= setup_nxt;
      status_r  <= status_nxt;
    end
  end

  // Bank and palette storage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < BANK_DEPTH; i++) begin
        bank_r[i] <= '0;
      end
      for (int j = 0; j < PAL_DEPTH; j++) begin
        palette_r[j] <= '0;
      end
    end else begin
      if (advance && bank_we) begin
        bank_r[index_r] <= in_item_r.write_data;
      end
      if (advance && pal_we) begin
        palette_r[pal_ptr_r] <= in_item_r.write_data[PAL_W-1:0];
      end
    end
  end

  // Window base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_base_r <= IO_BASE_RESET;
    end else if (cfg_wr_en) begin
      io_base_r <= cfg_wr_data;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_hit_r;

endmodule

@@ rtl/core/irpl_checker.sv @@
// Port-level checker for the indexed register port and its bind to the top level.
module irpl_checker
  import irpl_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_TDATA_W-1:0] in_tdata,
  input logic [0:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [DATA_W-1:0]     out_tdata,
  input logic [0:0]            out_tuser
);

  // A waiting input item keeps its payload until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && !in_tready |=> in_tvalid && $stable(in_tdata) && $stable(in_tuser))
    else $error("waiting input item changed");

  // A stalled item keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result item changed");

  // An access outside the window never returns data.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("missed access returned nonzero data");

  // Input back-pressure only comes from a full result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a blocked result");

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind indexed_register_port_with_palette_load_unit irpl_checker u_irpl_checker (.*);

@@ tb/indexed_register_port_with_palette_load_unit_test.sv @@
// Self-checking testbench for the indexed register port with palette load.
`timescale 1ns / 100ps

module indexed_register_port_with_palette_load_unit_test
  import irpl_pkg::*;
();

  localparam int STALL_LIMIT    = 2000;
  localparam int HOLDOFF_CYCLES = 64;
  localparam int MAX_REPORTS    = 10;

  // One result as the block should return it.
  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              port_hit;
  } port_reply_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_TDATA_W-1:0] in_tdata;   // [15:0] port, [23:16] write_data
  logic [0:0]            in_tuser;   // [0] command (0 read, 1 write)
  logic                  out_tvalid;
  logic                  out_tready;
  logic [DATA_W-1:0]     out_tdata;  // [7:0] read_data
  logic [0:0]            out_tuser;  // [0] port_hit
  logic                  cfg_wr_en;
  logic [PORT_W-1:0]     cfg_wr_data;

  // Shadow copy of the block state used for prediction.
  logic [PORT_W-1:0] io_base_model;
  logic [DATA_W-1:0] bank_model [BANK_DEPTH];
  logic [PAL_W-1:0]  palette_model [PAL_DEPTH];
  logic [IDX_W-1:0]  index_model;
  logic [PPTR_W-1:0] pointer_model;
  logic [DATA_W-1:0] mode_model;
  logic [DATA_W-1:0] setup_model;
  logic              status_model;

  port_reply_t expected_replies [$];

  int  error_count;
  int  accesses_sent;
  int  window_hits;
  int  replies_checked;
  int  bases_used;
  int  idle_cycles;
  bit  sender_gaps_on;
  bit  receiver_stalls_on;
  bit  holdoff_request;

  indexed_register_port_with_palette_load_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Predict the reply to one accepted access and advance the shadow state.
  function automatic port_reply_t predict_access(logic cmd, logic [PORT_W-1:0] port,
                                                 logic [DATA_W-1:0] wdata);
    port_reply_t       reply;
    logic [PORT_W:0]   window_lo;
    logic [PORT_W-1:0] distance;
    logic [OFF_W-1:0]  offset;
    window_lo = {1'b0, io_base_model};
    reply.read_data = '0;
    // The window compare is one bit wider so that it never wraps past the top port.
    reply.port_hit = ({1'b0, port} >= window_lo) && ({1'b0, port} < window_lo + 17'd16);
    if (reply.port_hit) begin
      window_hits++;
      distance = port - io_base_model;
      offset   = distance[OFF_W-1:0];
      if (cmd == CMD_WRITE) begin
        case (offset)
          OFF_INDEX: begin
            index_model = wdata[IDX_W-1:0];
            if (index_model == PAL_INDEX) pointer_model = '0;
          end
          OFF_DATA: begin
            // The palette index steers data writes away from the bank.
            if (index_model == PAL_INDEX) begin
              palette_model[pointer_model] = wdata[PAL_W-1:0];
              pointer_model = pointer_model + 1'b1;
            end else begin
              bank_model[index_model] = wdata;
            end
          end
          OFF_MODE:  mode_model = wdata;
          OFF_SETUP: setup_model = wdata;
          default: ;
        endcase
      end else begin
        case (offset)
          OFF_DATA: reply.read_data = bank_model[index_model];
          OFF_STATUS: begin
            status_model = ~status_model;
            reply.read_data = status_model ? STATUS_BITS : '0;
          end
          default: ;
        endcase
      end
    end
    return reply;
  endfunction

  // Offer one access and wait until the block takes it.
  task automatic send_access(input logic cmd, input logic [PORT_W-1:0] port,
                             input logic [DATA_W-1:0] wdata);
    int gap;
    if (sender_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {wdata, port};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    expected_replies.push_back(predict_access(cmd, port, wdata));
    accesses_sent++;
  endtask

  // Stop offering items.
  task automatic idle_input();
    in_tvalid <= 1'b0;
  endtask

  // Wait until every expected result has come back.
  task automatic wait_for_drain();
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Move the window; only done while the block is idle.
  task automatic write_io_base(input logic [PORT_W-1:0] base);
    idle_input();
    wait_for_drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    io_base_model = base;
    bases_used++;
  endtask

  function automatic logic [PORT_W-1:0] window_port(logic [OFF_W-1:0] offset);
    return io_base_model + PORT_W'(offset);
  endfunction

  function automatic logic [DATA_W-1:0] random_byte();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  // Result checker: each accepted result against the oldest expectation.
  always @(posedge clk) begin
    port_reply_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_replies.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected result read_data=%02h port_hit=%0b",
                   out_tdata, out_tuser[0]);
      end else begin
        want = expected_replies.pop_front();
        replies_checked++;
        if (out_tdata !== want.read_data || out_tuser[0] !== want.port_hit) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("ERROR: result %0d expected read_data=%02h port_hit=%0b, got %02h %0b",
                     replies_checked, want.read_data, want.port_hit, out_tdata, out_tuser[0]);
        end
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    int stall;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_request) begin
        out_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
        holdoff_request = 1'b0;
        out_tready <= 1'b1;
      end else if (receiver_stalls_on && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 18);
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake on either side.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("ERROR: no progress for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Status toggling, unmapped offsets, index reads and the window border.
  task automatic test_reset_window();
    send_access(CMD_READ,  window_port(OFF_STATUS), 8'hFF);
    send_access(CMD_READ,  window_port(OFF_STATUS), 8'h00);
    send_access(CMD_READ,  window_port(OFF_DATA), 8'h00);
    send_access(CMD_READ,  window_port(OFF_INDEX), 8'h00);
    send_access(CMD_WRITE, io_base_model - 16'd1, 8'hFF);
    send_access(CMD_READ,  io_base_model + 16'd16, 8'h00);
    send_access(CMD_READ,  window_port(OFF_SETUP), 8'h00);
    send_access(CMD_WRITE, window_port(4'h0), 8'hFF);
  endtask

  // Index masking and bank write then read back.
  task automatic test_bank_registers();
    send_access(CMD_WRITE, window_port(OFF_INDEX), 8'hFF);
    send_access(CMD_WRITE, window_port(OFF_DATA), 8'hFF);
    send_access(CMD_READ,  window_port(OFF_DATA), 8'h00);
    send_access(CMD_WRITE, window_port(OFF_INDEX), 8'h00);
    send_access(CMD_READ,  window_port(OFF_DATA), 8'hFF);
    send_access(CMD_WRITE, window_port(OFF_DATA), 8'hA5);
    send_access(CMD_READ,  window_port(OFF_DATA), 8'h00);
  endtask

  // Palette loads keep the bank byte at the palette index; write-only latches.
  task automatic test_palette_and_latches();
    send_access(CMD_WRITE, window_port(OFF_MODE), 8'hFF);
    send_access(CMD_WRITE, window_port(OFF_SETUP), 8'h00);
    send_access(CMD_WRITE, window_port(OFF_INDEX), {3'b111, PAL_INDEX});
    send_access(CMD_WRITE, window_port(OFF_DATA), 8'h3F);
    send_access(CMD_WRITE, window_port(OFF_DATA), 8'hC0);
    send_access(CMD_READ,  window_port(OFF_DATA), 8'h00);
    send_access(CMD_READ,  window_port(OFF_MODE), 8'h00);
  endtask

  // Window at the bottom and the top of the port space, including a clipped window.
  task automatic test_window_edges();
    write_io_base(16'h0000);
    send_access(CMD_READ,  16'h0000, 8'h00);
    send_access(CMD_READ,  16'h000A, 8'h00);
    send_access(CMD_READ,  16'h0010, 8'h00);
    send_access(CMD_READ,  16'hFFFF, 8'h00);
    write_io_base(16'hFFF0);
    send_access(CMD_WRITE, 16'hFFF4, 8'h03);
    send_access(CMD_READ,  16'hFFEF, 8'h00);
    send_access(CMD_READ,  16'hFFFF, 8'h00);
    write_io_base(16'hFFFA);
    send_access(CMD_READ,  16'hFFFA, 8'h00);
    send_access(CMD_READ,  16'hFFFF, 8'h00);
    send_access(CMD_READ,  16'h0009, 8'h00);
    send_access(CMD_READ,  16'hFFF9, 8'h00);
  endtask

  // One random sequence: mostly well-formed index and data traffic, some noise.
  task automatic random_sequence();
    int kind;
    int count;
    logic [IDX_W-1:0] idx;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      idx = IDX_W'($urandom_range(0, BANK_DEPTH - 1));
      send_access(CMD_WRITE, window_port(OFF_INDEX), {3'($urandom), idx});
      count = $urandom_range(1, 5);
      repeat (count)
        send_access(1'($urandom), window_port(OFF_DATA), random_byte());
    end else if (kind < 70) begin
      send_access(CMD_WRITE, window_port(OFF_INDEX), {3'($urandom), PAL_INDEX});
      count = $urandom_range(1, 20);
      repeat (count) send_access(CMD_WRITE, window_port(OFF_DATA), random_byte());
      send_access(CMD_READ, window_port(OFF_DATA), random_byte());
    end else if (kind < 80) begin
      count = $urandom_range(1, 3);
      repeat (count) send_access(CMD_READ, window_port(OFF_STATUS), random_byte());
    end else if (kind < 90) begin
      send_access(1'($urandom), window_port(OFF_W'($urandom)), random_byte());
    end else begin
      send_access(1'($urandom), PORT_W'($urandom), random_byte());
    end
  endtask

  // Random traffic over several window bases, the extremes among them.
  task automatic test_random_traffic();
    logic [PORT_W-1:0] bases [5];
    int target;
    bases[0] = IO_BASE_RESET;
    bases[1] = PORT_W'($urandom_range(0, 16'hFFF0));
    bases[2] = 16'hFFF0;
    bases[3] = PORT_W'($urandom_range(0, 16'hFFF0));
    bases[4] = 16'h0000;
    foreach (bases[i]) begin
      write_io_base(bases[i]);
      target = accesses_sent + 90;
      while (accesses_sent < target) random_sequence();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_output_holdoff();
    write_io_base(PORT_W'($urandom_range(0, 16'hFFF0)));
    sender_gaps_on  = 1'b0;
    holdoff_request = 1'b1;
    repeat (24) send_access(1'($urandom), window_port(OFF_W'($urandom)), random_byte());
    sender_gaps_on = 1'b1;
  endtask

  // Final stretch with no idling on either side.
  task automatic test_steady_stream();
    int target;
    sender_gaps_on     = 1'b0;
    receiver_stalls_on = 1'b0;
    target = accesses_sent + 50;
    while (accesses_sent < target) random_sequence();
  endtask

  // Main sequence.
  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= CMD_READ;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    error_count = 0;
    accesses_sent = 0;
    window_hits = 0;
    replies_checked = 0;
    bases_used = 1;
    idle_cycles = 0;
    sender_gaps_on = 1'b1;
    receiver_stalls_on = 1'b1;
    holdoff_request = 1'b0;
    io_base_model = IO_BASE_RESET;
    foreach (bank_model[i]) bank_model[i] = '0;
    foreach (palette_model[i]) palette_model[i] = '0;
    index_model   = '0;
    pointer_model = '0;
    mode_model    = '0;
    setup_model   = '0;
    status_model  = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_window();
    test_bank_registers();
    test_palette_and_latches();
    test_window_edges();
    test_random_traffic();
    test_output_holdoff();
    test_steady_stream();

    idle_input();
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d accesses, %0d inside the window, across %0d window bases.",
             accesses_sent, window_hits, bases_used);
    $display("Checked %0d results with %0d mismatches.", replies_checked, error_count);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
